[rtl/core/mf3_pkg.sv]
// ----------------------------------------------------------------------------
// mf3_pkg: shared definitions for the 3x3 median filter
// Register indexes, fixed field widths, parameter defaults and the
// raster position flags that travel from the position counters to the window.
// ----------------------------------------------------------------------------
package mf3_pkg;

    // Parameter defaults.
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int PIXEL_BITS_DEF = 8;

    // Window geometry.
    localparam int WIN_ROWS = 3;
    localparam int WIN_TAPS = 9;

    // Configuration register widths and port geometry.
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 12;
    localparam int CFG_DATA_W   = 12;
    localparam int CFG_INDEX_W  = 1;

    // Row counter: rows run up to height + 1 during the flush.
    localparam int ROW_W = 13;

    // Reset values of the configuration registers.
    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 12'd1;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    // Position flags of one item, taken from the raster counters.
    typedef struct packed {
        logic row_ge1;   // a row above exists in the image
        logic row_ge2;   // two rows above exist in the image
        logic col_zero;  // item sits in column zero
        logic col_ge2;   // item sits in column two or later
        logic wide;      // image is at least two pixels wide
        logic past_end;  // item lies after the last image row
        logic emit;      // item completes a window
        logic last;      // item completes the window of the final pixel
    } mf3_pos_t;

endpackage

[rtl/core/mf3_stream_if.sv]
// ----------------------------------------------------------------------------
// mf3 stream interfaces
// Valid/ready channels for incoming pixels and outgoing medians.
// ----------------------------------------------------------------------------

// Pixel channel: one raster position per item.
interface mf3_pix_if #(
    parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [PIXEL_BITS-1:0] pixel;

    modport source (output valid, output req_type, output pixel, input ready);
    modport sink   (input valid, input req_type, input pixel, output ready);
endinterface

// Median channel: one filtered pixel per item.
interface mf3_med_if #(
    parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] median;
    logic                  last_of_frame;

    modport source (output valid, output median, output last_of_frame, input ready);
    modport sink   (input valid, input median, input last_of_frame, output ready);
endinterface

[rtl/core/mf3_raster_ctrl.sv]
// ----------------------------------------------------------------------------
// mf3_raster_ctrl: configuration registers and raster position counters
// Holds image width and height, tracks the column and row of the next item
// and derives the position flags that steer the window and the output.
// ----------------------------------------------------------------------------
module mf3_raster_ctrl #(
    parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEF,
    localparam int COL_W = $clog2(MAX_WIDTH)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mf3_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mf3_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            accept,
    output logic [COL_W-1:0]                col,
    output mf3_pkg::mf3_pos_t               pos
);

    logic [mf3_pkg::WIDTH_REG_W-1:0]  width_reg;
    logic [mf3_pkg::HEIGHT_REG_W-1:0] height_reg;
    logic [mf3_pkg::WIDTH_REG_W-1:0]  w_eff;
    logic [mf3_pkg::HEIGHT_REG_W-1:0] h_eff;
    logic [COL_W-1:0]                 col_reg;
    logic [COL_W-1:0]                 col_next;
    logic [mf3_pkg::ROW_W-1:0]        row_reg;
    logic [mf3_pkg::ROW_W-1:0]        row_next;
    logic [mf3_pkg::ROW_W-1:0]        h_ext;
    logic                             col_last;

    // Effective geometry: zero counts as one, too wide counts as the maximum.
    always_comb
    begin
        if (width_reg == '0)
            w_eff = mf3_pkg::WIDTH_REG_W'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            w_eff = mf3_pkg::WIDTH_REG_W'(MAX_WIDTH);
        else
            w_eff = width_reg;
        h_eff = (height_reg == '0) ? mf3_pkg::HEIGHT_REG_W'(1) : height_reg;
        h_ext = mf3_pkg::ROW_W'(h_eff);
    end

    // Position flags of the item at the current counters.
    always_comb
    begin
        col_last     = (32'(col_reg) + 32'd1) == 32'(w_eff);
        col          = col_reg;
        pos.row_ge1  = row_reg != '0;
        pos.row_ge2  = row_reg >= mf3_pkg::ROW_W'(2);
        pos.col_zero = col_reg == '0;
        pos.col_ge2  = 32'(col_reg) >= 32'd2;
        pos.wide     = w_eff >= mf3_pkg::WIDTH_REG_W'(2);
        pos.past_end = row_reg >= h_ext;
        pos.emit     = (row_reg >= mf3_pkg::ROW_W'(2))
                     || ((row_reg == mf3_pkg::ROW_W'(1)) && (col_reg != '0));
        pos.last     = (row_reg == h_ext + mf3_pkg::ROW_W'(1)) && (col_reg == '0);
    end

    // Counter advance: restart on a register write or after the final window.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_we)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (pos.last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (col_last)
            begin
                col_next = '0;
                row_next = row_reg + mf3_pkg::ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    // Counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= mf3_pkg::WIDTH_RESET;
            height_reg <= mf3_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mf3_pkg::REG_IMAGE_WIDTH:
                    width_reg <= cfg_data[mf3_pkg::WIDTH_REG_W-1:0];
                mf3_pkg::REG_IMAGE_HEIGHT:
                    height_reg <= cfg_data[mf3_pkg::HEIGHT_REG_W-1:0];
                default:
                    width_reg <= width_reg;
            endcase
        end
    end

    // The column counter stays inside the current row.
    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        32'(col_reg) < 32'(w_eff))
        else $error("column counter beyond image width");

    // Rows never run past the flush row.
    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= h_ext + mf3_pkg::ROW_W'(1))
        else $error("row counter beyond flush row");

    // The final window restarts the frame.
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && pos.last && !cfg_we) |=> (col_reg == '0) && (row_reg == '0))
        else $error("counters did not restart after the final window");

endmodule

[rtl/core/mf3_line_mem.sv]
// ----------------------------------------------------------------------------
// mf3_line_mem: line store for the two previous image rows
// One word per column holds the pixel two rows up and the pixel one row up.
// Synchronous read with registered read data; a write to the address being
// read in the same cycle is forwarded into the read data.
// ----------------------------------------------------------------------------
module mf3_line_mem #(
    parameter int DEPTH  = mf3_pkg::MAX_WIDTH_DEF,
    parameter int DATA_W = 2 * mf3_pkg::PIXEL_BITS_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Read port with write-through forwarding.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
                rd_data_reg <= wr_data;
            else
                rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/mf3_window.sv]
// ----------------------------------------------------------------------------
// mf3_window: line store update and 3x3 window assembly
// The item waits in a register for its line store word, then builds the newest
// column, writes the line store back, shifts the window columns and hands the
// nine window values onward when the item completes a window.
// ----------------------------------------------------------------------------
module mf3_window #(
    parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF,
    localparam int COL_W = $clog2(MAX_WIDTH)
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    // Incoming item and its position.
    input  logic                                            item_valid,
    output logic                                            item_ready,
    input  logic                                            req_type,
    input  logic [PIXEL_BITS-1:0]                           pixel,
    input  logic [COL_W-1:0]                                col,
    input  mf3_pkg::mf3_pos_t                               pos,
    // Line store port.
    output logic                                            rd_en,
    output logic [COL_W-1:0]                                rd_addr,
    input  logic [2*PIXEL_BITS-1:0]                         rd_data,
    output logic                                            wr_en,
    output logic [COL_W-1:0]                                wr_addr,
    output logic [2*PIXEL_BITS-1:0]                         wr_data,
    // Completed window.
    output logic                                            win_valid,
    input  logic                                            win_ready,
    output logic [mf3_pkg::WIN_TAPS-1:0][PIXEL_BITS-1:0]    win,
    output logic                                            win_last
);

    localparam int R = mf3_pkg::WIN_ROWS;

    logic                                          m_valid_reg;
    logic [PIXEL_BITS-1:0]                         m_px_reg;
    logic [COL_W-1:0]                              m_col_reg;
    mf3_pkg::mf3_pos_t                             m_pos_reg;
    logic                                          m_adv;
    logic                                          accept;
    logic [R-1:0][PIXEL_BITS-1:0]                  left_reg;
    logic [R-1:0][PIXEL_BITS-1:0]                  mid_reg;
    logic [R-1:0][PIXEL_BITS-1:0]                  col_v;
    logic [mf3_pkg::WIN_TAPS-1:0][PIXEL_BITS-1:0]  win_next;
    logic                                          s1_valid_reg;
    logic                                          s1_valid_next;
    logic [mf3_pkg::WIN_TAPS-1:0][PIXEL_BITS-1:0]  s1_win_reg;
    logic                                          s1_last_reg;

    // Handshake: the waiting item moves on unless its window cannot be placed.
    always_comb
    begin
        m_adv      = m_valid_reg && (!m_pos_reg.emit || !s1_valid_reg || win_ready);
        item_ready = !m_valid_reg || m_adv;
        accept     = item_valid && item_ready;
    end

    // Line store read for the accepted item; write back when it moves on.
    always_comb
    begin
        rd_en   = accept;
        rd_addr = col;
        wr_en   = m_adv;
        wr_addr = m_col_reg;
        wr_data = {rd_data[PIXEL_BITS-1:0], m_px_reg};
    end

    // Newest column and window assembly, with zero outside the image.
    always_comb
    begin
        col_v[0] = m_pos_reg.row_ge2 ? rd_data[2*PIXEL_BITS-1:PIXEL_BITS] : '0;
        col_v[1] = m_pos_reg.row_ge1 ? rd_data[PIXEL_BITS-1:0] : '0;
        col_v[2] = m_px_reg;
        win_next = '0;
        for (int i = 0; i < R; i++)
        begin
            win_next[R + i] = mid_reg[i];
            if (m_pos_reg.col_zero)
            begin
                // Centre is the last column of the row before: right side is zero.
                win_next[i] = m_pos_reg.wide ? left_reg[i] : '0;
            end
            else
            begin
                win_next[i]         = m_pos_reg.col_ge2 ? left_reg[i] : '0;
                win_next[2 * R + i] = col_v[i];
            end
        end
    end

    // Waiting item registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (item_ready)
            m_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_px_reg  <= (req_type || pos.past_end) ? '0 : pixel;
            m_col_reg <= col;
            m_pos_reg <= pos;
        end
    end

    // Window column shift.
    always_ff @(posedge clk)
    begin
        if (m_adv)
        begin
            left_reg <= mid_reg;
            mid_reg  <= col_v;
        end
    end

    // Completed window register.
    always_comb
    begin
        if (m_adv && m_pos_reg.emit)
            s1_valid_next = 1'b1;
        else if (win_ready)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (m_adv && m_pos_reg.emit)
        begin
            s1_win_reg  <= win_next;
            s1_last_reg <= m_pos_reg.last;
        end
    end

    assign win_valid = s1_valid_reg;
    assign win       = s1_win_reg;
    assign win_last  = s1_last_reg;

    // The line store is written only by an item that has its read data.
    a_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> m_valid_reg && !$isunknown(m_col_reg))
        else $error("line store written without a waiting item");

endmodule

[rtl/core/mf3_median_sort.sv]
// ----------------------------------------------------------------------------
// mf3_median_sort: pipelined median of nine
// Sorts each window column, takes the largest minimum, the median of the
// medians and the smallest maximum, and gives the median of those three.
// The last stage is the output register.
// ----------------------------------------------------------------------------
module mf3_median_sort #(
    parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          win_valid,
    output logic                                          win_ready,
    input  logic [mf3_pkg::WIN_TAPS-1:0][PIXEL_BITS-1:0]  win,
    input  logic                                          win_last,
    output logic                                          res_valid,
    input  logic                                          res_ready,
    output logic [PIXEL_BITS-1:0]                         median,
    output logic                                          last_of_frame
);

    localparam int R = mf3_pkg::WIN_ROWS;

    typedef logic [PIXEL_BITS-1:0] pix_t;

    function automatic pix_t min2(input pix_t a, input pix_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pix_t max2(input pix_t a, input pix_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    logic                      v2_reg, v3_reg, v4_reg;
    logic                      r2, r3, r4;
    logic [R-1:0][R-1:0][PIXEL_BITS-1:0] srt_reg;   // [column][lo, mid, hi]
    logic [R-1:0][R-1:0][PIXEL_BITS-1:0] srt_next;
    logic                      last2_reg, last3_reg, last4_reg;
    pix_t                      lo_reg, md_reg, hi_reg;
    pix_t                      med_reg;

    // Stage readiness: a stage loads when empty or when it drains.
    always_comb
    begin
        r4        = !v4_reg || res_ready;
        r3        = !v3_reg || r4;
        r2        = !v2_reg || r3;
        win_ready = r2;
    end

    // Column sort.
    always_comb
    begin
        for (int c = 0; c < R; c++)
        begin
            srt_next[c][0] = min2(min2(win[R*c], win[R*c+1]), win[R*c+2]);
            srt_next[c][1] = med3(win[R*c], win[R*c+1], win[R*c+2]);
            srt_next[c][2] = max2(max2(win[R*c], win[R*c+1]), win[R*c+2]);
        end
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (r2)
                v2_reg <= win_valid;
            if (r3)
                v3_reg <= v2_reg;
            if (r4)
                v4_reg <= v3_reg;
        end
    end

    // Sorted columns.
    always_ff @(posedge clk)
    begin
        if (r2 && win_valid)
        begin
            srt_reg   <= srt_next;
            last2_reg <= win_last;
        end
    end

    // Largest minimum, median of medians, smallest maximum.
    always_ff @(posedge clk)
    begin
        if (r3 && v2_reg)
        begin
            lo_reg    <= max2(max2(srt_reg[0][0], srt_reg[1][0]), srt_reg[2][0]);
            md_reg    <= med3(srt_reg[0][1], srt_reg[1][1], srt_reg[2][1]);
            hi_reg    <= min2(min2(srt_reg[0][2], srt_reg[1][2]), srt_reg[2][2]);
            last3_reg <= last2_reg;
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (r4 && v3_reg)
        begin
            med_reg   <= med3(lo_reg, md_reg, hi_reg);
            last4_reg <= last3_reg;
        end
    end

    assign res_valid     = v4_reg;
    assign median        = med_reg;
    assign last_of_frame = last4_reg;

    // The median lies between the largest minimum and the smallest maximum.
    a_median_range: assert property (@(posedge clk) disable iff (!rst_n)
        (r4 && v3_reg && (lo_reg <= hi_reg))
            |=> (med_reg >= $past(lo_reg)) && (med_reg <= $past(hi_reg)))
        else $error("median outside the bracketing values");

endmodule

[rtl/core/median_filter_3x3_unit.sv]
// ----------------------------------------------------------------------------
// median_filter_3x3_unit: streaming 3x3 median filter
// Takes a greyscale image in raster order, one pixel per item, followed by
// width + 1 flush items, and gives the median of each pixel's 3x3
// neighbourhood with zero outside the image. The final median of a frame is
// flagged and the raster counters then restart.
//
//   Channel        Dir  Handshake     Payload
//   pixel_stream   in   valid/ready   req_type, pixel
//   median_stream  out  valid/ready   median, last_of_frame
//   cfg            in   cfg_we        cfg_index, cfg_data (write only)
//
// One item per cycle unless the output stalls; the line store does one read
// and one write per cycle, and a same-column write is forwarded into the next read.
// A median reaches the output register through the window and sort stages;
// the first width + 1 items of a frame give none.
// Reset initialises only the configuration registers, counters and valid bits;
// the line store needs no clearing pass; rows of older frames are masked to zero.
// A stalled output fills the four pipeline stages before input is held off.
// ----------------------------------------------------------------------------
module median_filter_3x3_unit #(
    parameter int MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = mf3_pkg::PIXEL_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mf3_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mf3_pkg::CFG_DATA_W-1:0]  cfg_data,
    mf3_pix_if.sink                         pixel_stream,
    mf3_med_if.source                       median_stream
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic                                          accept;
    logic                                          item_ready;
    logic [COL_W-1:0]                              col;
    mf3_pkg::mf3_pos_t                             pos;
    logic                                          rd_en;
    logic [COL_W-1:0]                              rd_addr;
    logic [2*PIXEL_BITS-1:0]                       rd_data;
    logic                                          wr_en;
    logic [COL_W-1:0]                              wr_addr;
    logic [2*PIXEL_BITS-1:0]                       wr_data;
    logic                                          win_valid;
    logic                                          win_ready;
    logic [mf3_pkg::WIN_TAPS-1:0][PIXEL_BITS-1:0]  win;
    logic                                          win_last;

    // Input handshake.
    assign pixel_stream.ready = item_ready;
    assign accept             = pixel_stream.valid && item_ready;

    // Registers and raster position.
    mf3_raster_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .col       (col),
        .pos       (pos)
    );

    // Line store for the two rows above.
    mf3_line_mem #(
        .DEPTH  (MAX_WIDTH),
        .DATA_W (2 * PIXEL_BITS)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Window assembly.
    mf3_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (pixel_stream.valid),
        .item_ready (item_ready),
        .req_type   (pixel_stream.req_type),
        .pixel      (pixel_stream.pixel),
        .col        (col),
        .pos        (pos),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .win_valid  (win_valid),
        .win_ready  (win_ready),
        .win        (win),
        .win_last   (win_last)
    );

    // Median network and output register.
    mf3_median_sort #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_sort (
        .clk           (clk),
        .rst_n         (rst_n),
        .win_valid     (win_valid),
        .win_ready     (win_ready),
        .win           (win),
        .win_last      (win_last),
        .res_valid     (median_stream.valid),
        .res_ready     (median_stream.ready),
        .median        (median_stream.median),
        .last_of_frame (median_stream.last_of_frame)
    );

endmodule
